>>> rtl/ptw_pkg.sv
`default_nettype none
package ptw_pkg;

    localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam int IDX_W = 9;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_REMAP = 2'd1,
        OP_XLATE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_OUTSIDE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_ZERO,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        logic    wr_leaf;
        logic    wr_link;
        logic    wr_zero;
        logic    descend;
        logic    lvl_dec;
        logic    set_st;
        status_t st_code;
        logic    set_res;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic op_none;
        logic is_map;
        logic is_xlate;
        logic stop;
        logic present;
        logic outside;
        logic full;
        logic zero_last;
        logic out_free;
    } sts_t;

    function automatic logic [IDX_W-1:0] level_index(input logic [47:0] va,
                                                     input logic [2:0] lvl);
        logic [IDX_W-1:0] idx;
        idx = '0;
        case (lvl)
            3'd1: idx = va[20:12];
            3'd2: idx = va[29:21];
            3'd3: idx = va[38:30];
            3'd4: idx = va[47:39];
            default: idx = '0;
        endcase
        return idx;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ptw_ram.sv
`default_nettype none
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/ptw_ctrl.sv
`default_nettype none
module ptw_ctrl
    import ptw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.st_code = ST_OK;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_zero = 1'b1;
                if (sts.zero_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.op_none)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                if (sts.stop)
                begin
                    if (!sts.is_xlate)
                    begin
                        cmd.wr_leaf = 1'b1;
                    end
                    else if (sts.present)
                    begin
                        cmd.set_res = 1'b1;
                    end
                    else
                    begin
                        cmd.set_st  = 1'b1;
                        cmd.st_code = ST_ABSENT;
                    end
                end
                else if (sts.present)
                begin
                    if (sts.outside)
                    begin
                        cmd.set_st  = 1'b1;
                        cmd.st_code = ST_OUTSIDE;
                    end
                    else
                    begin
                        cmd.descend = 1'b1;
                        state_next  = S_READ;
                    end
                end
                else if (!sts.is_map)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_ABSENT;
                end
                else if (sts.full)
                begin
                    cmd.set_st  = 1'b1;
                    cmd.st_code = ST_FULL;
                end
                else
                begin
                    cmd.wr_link = 1'b1;
                    state_next  = S_ZERO;
                end
            end
            S_ZERO:
            begin
                cmd.wr_zero = 1'b1;
                if (sts.zero_last)
                begin
                    cmd.lvl_dec = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/ptw_dp.sv
`default_nettype none
module ptw_dp
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 16,
    parameter int WALK_LEVELS  = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  op,
    input  wire logic [47:0] vaddr,
    input  wire logic [51:0] paddr,
    input  wire logic [63:0] flags,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [51:0]      phys_result,
    input  wire cmd_t        cmd,
    output sts_t             sts
);
    localparam int FW = $clog2(TABLE_FRAMES);
    localparam int NW = $clog2(TABLE_FRAMES + 1);
    localparam int AW = FW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * (1 << IDX_W);

    logic [1:0]       op_reg;
    logic [47:0]      va_reg;
    logic [51:0]      pa_reg;
    logic [63:0]      flags_reg;
    logic [FW-1:0]    frame_reg;
    logic [2:0]       lvl_reg;
    logic [NW-1:0]    nff_reg;
    logic [IDX_W-1:0] cnt_reg;
    status_t          st_reg;
    logic [51:0]      res_reg;
    logic             out_valid_reg;
    logic [1:0]       status_reg;
    logic [51:0]      phys_result_reg;

    logic [63:0]      entry;
    logic [IDX_W-1:0] idx;
    logic [AW-1:0]    addr;
    logic [63:0]      wdata;
    logic             we;
    logic [39:0]      ptr;
    logic             page_size;

    assign idx       = level_index(va_reg, lvl_reg);
    assign ptr       = entry[51:12];
    assign page_size = (op_reg == OP_XLATE) ? entry[7] : flags_reg[7];
    assign addr      = cmd.wr_zero ? {frame_reg, cnt_reg} : {frame_reg, idx};
    assign we        = cmd.wr_zero | cmd.wr_link | cmd.wr_leaf;

    always_comb
    begin
        wdata = '0;
        if (cmd.wr_link)
        begin
            wdata = (64'(nff_reg) << 12) | 64'h3;
        end
        else if (cmd.wr_leaf)
        begin
            if (op_reg == OP_MAP)
            begin
                wdata = ({12'b0, pa_reg} & ADDR_MASK) | (flags_reg & ~ADDR_MASK);
            end
            else
            begin
                wdata = (entry & ADDR_MASK) | (flags_reg & ~ADDR_MASK);
            end
        end
    end

    ptw_ram #(
        .WIDTH(64),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .rdata(entry)
    );

    always_comb
    begin
        sts.op_none   = (op_reg == OP_NONE);
        sts.is_map    = (op_reg == OP_MAP);
        sts.is_xlate  = (op_reg == OP_XLATE);
        sts.stop      = (lvl_reg == 3'd1) || (lvl_reg == 3'd2 && page_size);
        sts.present   = entry[0];
        sts.outside   = (ptr >= 40'(TABLE_FRAMES));
        sts.full      = (nff_reg >= NW'(TABLE_FRAMES));
        sts.zero_last = (cnt_reg == {IDX_W{1'b1}});
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= op;
            va_reg    <= vaddr;
            pa_reg    <= paddr;
            flags_reg <= flags;
        end
        if (cmd.load_item)
        begin
            res_reg <= '0;
        end
        else if (cmd.set_res)
        begin
            res_reg <= entry[51:0] & ADDR_MASK[51:0];
        end
        if (cmd.load_item)
        begin
            st_reg <= ST_OK;
        end
        else if (cmd.set_st)
        begin
            st_reg <= cmd.st_code;
        end
        if (cmd.out_load)
        begin
            status_reg      <= st_reg;
            phys_result_reg <= (st_reg == ST_OK) ? res_reg : 52'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= '0;
            lvl_reg       <= 3'(WALK_LEVELS);
            nff_reg       <= NW'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                frame_reg <= '0;
                lvl_reg   <= 3'(WALK_LEVELS);
            end
            else if (cmd.descend)
            begin
                frame_reg <= ptr[FW-1:0];
                lvl_reg   <= lvl_reg - 3'd1;
            end
            else if (cmd.wr_link)
            begin
                frame_reg <= nff_reg[FW-1:0];
                nff_reg   <= nff_reg + NW'(1);
            end
            else if (cmd.lvl_dec)
            begin
                lvl_reg <= lvl_reg - 3'd1;
            end
            if (cmd.wr_zero)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign phys_result = phys_result_reg;

    a_nff_range: assert property (@(posedge clk) disable iff (!rst_n)
        nff_reg >= NW'(1) && nff_reg <= NW'(TABLE_FRAMES))
        else $error("frame counter out of range");
    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg >= 3'd1 && lvl_reg <= 3'(WALK_LEVELS))
        else $error("walk level out of range");
    a_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(we && cmd.rd_en))
        else $error("store read and written in one cycle");
    a_link_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_link |=> nff_reg == $past(nff_reg) + NW'(1))
        else $error("allocation did not advance the counter");
endmodule
`default_nettype wire

>>> rtl/four_level_page_table_walker.sv
// Walks x86-64 style page tables kept in an internal store of TABLE_FRAMES frames of 512
// entries, frame 0 being the root. After reset the block clears the root frame and takes
// no beat until then. Each table level is read through the single store port: S_READ
// issues the registered read and S_EVAL evaluates the entry; S_IDLE accepts the operation
// and S_DONE presents its result. Every table that map allocates has its frame cleared in
// S_ZERO before the walk goes on; the link entry is written in the cycle that finds the
// missing table. One operation is in flight at a time; the next beat is taken while the
// previous result still waits in the output register.
`default_nettype none
module four_level_page_table_walker
    import ptw_pkg::*;
#(
    parameter int TABLE_FRAMES = 16,
    parameter int WALK_LEVELS  = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [47:0] vaddr,
    input  wire logic [51:0] paddr,
    input  wire logic [63:0] flags,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [51:0]      phys_result
);
    cmd_t cmd;
    sts_t sts;

    ptw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sts     (sts),
        .cmd     (cmd)
    );

    ptw_dp #(
        .TABLE_FRAMES(TABLE_FRAMES),
        .WALK_LEVELS (WALK_LEVELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (op),
        .vaddr      (vaddr),
        .paddr      (paddr),
        .flags      (flags),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .phys_result(phys_result),
        .cmd        (cmd),
        .sts        (sts)
    );
endmodule
`default_nettype wire
